FILE: hdl/csl_pkg.sv
`default_nettype none
package csl_pkg;

   localparam int TEXT_LIMIT = 65536;
   localparam logic [16:0] POS_LAST = 17'(TEXT_LIMIT - 1);

   localparam logic [2:0] K_NUM      = 3'd0;
   localparam logic [2:0] K_STR      = 3'd1;
   localparam logic [2:0] K_IDENT    = 3'd2;
   localparam logic [2:0] K_KW       = 3'd3;
   localparam logic [2:0] K_PUNCT    = 3'd4;
   localparam logic [2:0] K_EOF      = 3'd5;
   localparam logic [2:0] K_UNCLOSED = 3'd6;
   localparam logic [2:0] K_INVALID  = 3'd7;

   localparam logic [2:0] M_IDLE  = 3'd0;
   localparam logic [2:0] M_NUM   = 3'd1;
   localparam logic [2:0] M_STR   = 3'd2;
   localparam logic [2:0] M_IDENT = 3'd3;
   localparam logic [2:0] M_PEND  = 3'd4;
   localparam logic [2:0] M_ERR   = 3'd5;

   // byte class from the front end
   localparam logic [2:0] C_SPACE = 3'd0;
   localparam logic [2:0] C_DIGIT = 3'd1;
   localparam logic [2:0] C_ALPHA = 3'd2;
   localparam logic [2:0] C_QUOTE = 3'd3;
   localparam logic [2:0] C_PEND  = 3'd4;
   localparam logic [2:0] C_PUNCT = 3'd5;
   localparam logic [2:0] C_BAD   = 3'd6;
   localparam logic [2:0] C_ZERO  = 3'd7;

   localparam int QDEPTH = 4;
   localparam int QAW    = 2;
   localparam int RDEPTH = 4;
   localparam int RAW    = 2;

   typedef struct packed {
      logic [7:0] ch;
      logic [2:0] cls;
      logic       is_eq;
      logic       is_nl;
   } byte_item_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [2:0]  kw;
      logic [15:0] off;
      logic [16:0] len;
      logic [63:0] val;
      logic        last;
   } token_type;

   function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] i);
      logic [47:0] s;
      begin
         unique case (k)
            3'd0: s = "return";
            3'd1: s = {"if", 32'h0};
            3'd2: s = {"else", 16'h0};
            3'd3: s = {"for", 24'h0};
            3'd4: s = {"while", 8'h0};
            3'd5: s = {"int", 24'h0};
            3'd6: s = "sizeof";
            default: s = {"char", 16'h0};
         endcase
         kw_char = (i > 3'd5) ? 8'h0 : s[8'(47 - 8 * int'(i)) -: 8];
      end
   endfunction

   function automatic logic [2:0] kw_len(input logic [2:0] k);
      begin
         unique case (k)
            3'd0: kw_len = 3'd6;
            3'd1: kw_len = 3'd2;
            3'd2: kw_len = 3'd4;
            3'd3: kw_len = 3'd3;
            3'd4: kw_len = 3'd5;
            3'd5: kw_len = 3'd3;
            3'd6: kw_len = 3'd6;
            default: kw_len = 3'd4;
         endcase
      end
   endfunction

endpackage
`default_nettype wire

FILE: hdl/csl_front.sv
`default_nettype none
// Classifies each byte and buffers it in a short queue for the back end.
module csl_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire logic [7:0]             text_byte,
   output logic                        full,
   output logic                        q_valid,
   output csl_pkg::byte_item_type      q_item,
   input  wire logic                   q_take
);
   csl_pkg::byte_item_type mem_ff [csl_pkg::QDEPTH];
   logic [csl_pkg::QAW:0] wp_ff, wp_in, rp_ff, rp_in;
   csl_pkg::byte_item_type cl;
   logic [7:0] c;
   logic wr;

   assign c = text_byte;
   always_comb begin
      cl.ch = c;
      cl.is_eq = (c == 8'h3D);
      cl.is_nl = (c == 8'h0A);
      if (c == 8'h00) cl.cls = csl_pkg::C_ZERO;
      else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) cl.cls = csl_pkg::C_SPACE;
      else if (c >= 8'h30 && c <= 8'h39) cl.cls = csl_pkg::C_DIGIT;
      else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F)
         cl.cls = csl_pkg::C_ALPHA;
      else if (c == 8'h22) cl.cls = csl_pkg::C_QUOTE;
      else if (c == 8'h3D || c == 8'h21 || c == 8'h3C || c == 8'h3E)
         cl.cls = csl_pkg::C_PEND;
      else if (c >= 8'h21 && c <= 8'h7E) cl.cls = csl_pkg::C_PUNCT;
      else cl.cls = csl_pkg::C_BAD;
   end

   assign full    = (wp_ff[csl_pkg::QAW] != rp_ff[csl_pkg::QAW]) &&
                    (wp_ff[csl_pkg::QAW-1:0] == rp_ff[csl_pkg::QAW-1:0]);
   assign q_valid = (wp_ff != rp_ff);
   assign wr      = push && !full;
   assign wp_in   = wp_ff + (csl_pkg::QAW+1)'(wr);
   assign rp_in   = rp_ff + (csl_pkg::QAW+1)'(q_take && q_valid);

   always_comb q_item = mem_ff[rp_ff[csl_pkg::QAW-1:0]];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
      end
      if (wr) mem_ff[wp_ff[csl_pkg::QAW-1:0]] <= cl;
   end
endmodule
`default_nettype wire

FILE: hdl/csl_back.sv
`default_nettype none
// Lexer state machine; emits up to two tokens per byte into a result queue.
module csl_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_valid,
   input  wire csl_pkg::byte_item_type q_item,
   output logic                        q_take,
   output logic                        empty,
   input  wire logic                   pop,
   output csl_pkg::token_type          tok
);
   logic [2:0]  mode_ff, mode_in;
   logic [16:0] pos_ff, pos_in;
   logic [15:0] start_ff, start_in;
   logic [63:0] acc_ff, acc_in;
   logic [7:0]  cand_ff, cand_in;

   csl_pkg::token_type t0, t1;
   logic n0, n1;

   csl_pkg::token_type rq_ff [csl_pkg::RDEPTH];
   logic [csl_pkg::RAW:0] rw_ff, rr_ff, cnt;

   logic [7:0]  c;
   logic [2:0]  cls;
   logic        over, fresh, rewind;
   logic [16:0] tlen;
   logic [63:0] acc10, accsum;
   logic        acc_ovf;
   logic [7:0]  narrowed, first_cand;
   logic [16:0] idx;

   assign cnt    = rw_ff - rr_ff;
   assign q_take = q_valid && (cnt <= (csl_pkg::RAW+1)'(csl_pkg::RDEPTH - 2));
   assign empty  = (cnt == '0);
   assign tok    = rq_ff[rr_ff[csl_pkg::RAW-1:0]];

   assign c    = q_item.ch;
   assign cls  = q_item.cls;
   assign over = pos_ff >= csl_pkg::POS_LAST;
   assign tlen = pos_ff - {1'b0, start_ff};
   assign idx  = tlen;

   // saturating acc*10 + d; overflow if acc > (2^64-1-d)/10
   always_comb begin
      logic [67:0] p;
      p = {4'b0, acc_ff} * 68'd10 + {64'b0, c[3:0] - 4'd0} - 68'd0;
      p = {4'b0, acc_ff} * 68'd10 + 68'(c - 8'h30);
      acc_ovf = |p[67:64];
      accsum  = p[63:0];
      acc10   = acc_ovf ? '1 : accsum;
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         narrowed[i] = cand_ff[i] && (idx < 17'd7) &&
                       (idx < 17'(csl_pkg::kw_len(3'(i)))) &&
                       (csl_pkg::kw_char(3'(i), idx[2:0]) == c);
         first_cand[i] = (csl_pkg::kw_char(3'(i), 3'd0) == c);
      end
   end

   function automatic csl_pkg::token_type mk(input logic [2:0] k, input logic [2:0] kw,
                                             input logic [15:0] off, input logic [16:0] len,
                                             input logic [63:0] v);
      csl_pkg::token_type r;
      begin
         r.kind = k; r.kw = kw; r.off = off; r.len = len; r.val = v; r.last = 1'b0;
         mk = r;
      end
   endfunction

   function automatic csl_pkg::token_type ident_tok(input logic [7:0] cand,
                                                    input logic [15:0] off,
                                                    input logic [16:0] len);
      csl_pkg::token_type r;
      logic hit;
      begin
         r = mk(csl_pkg::K_IDENT, 3'd0, off, len, 64'd0);
         hit = 1'b0;
         for (int i = 0; i < 8; i++)
            if (!hit && cand[i] && 17'(csl_pkg::kw_len(3'(i))) == len) begin
               hit = 1'b1;
               r.kind = csl_pkg::K_KW;
               r.kw = 3'(i);
            end
         ident_tok = r;
      end
   endfunction

   always_comb begin
      mode_in = mode_ff; pos_in = pos_ff; start_in = start_ff;
      acc_in = acc_ff; cand_in = cand_ff;
      t0 = mk(csl_pkg::K_NUM, 3'd0, 16'd0, 17'd0, 64'd0); t1 = t0;
      n0 = 1'b0; n1 = 1'b0; fresh = 1'b0; rewind = 1'b0;
      if (cls == csl_pkg::C_ZERO) begin
         rewind = 1'b1;
         unique case (mode_ff)
            csl_pkg::M_NUM: begin
               n0 = 1'b1; t0 = mk(csl_pkg::K_NUM, 3'd0, start_ff, tlen, acc_ff);
            end
            csl_pkg::M_IDENT: begin
               n0 = 1'b1; t0 = ident_tok(cand_ff, start_ff, tlen);
            end
            csl_pkg::M_PEND: begin
               n0 = 1'b1; t0 = mk(csl_pkg::K_PUNCT, 3'd0, start_ff, 17'd1, 64'd0);
            end
            default: ;
         endcase
         if (mode_ff == csl_pkg::M_STR) begin
            n0 = 1'b1; t0 = mk(csl_pkg::K_UNCLOSED, 3'd0, start_ff, 17'd0, 64'd0);
         end else if (mode_ff != csl_pkg::M_ERR) begin
            if (n0) begin
               n1 = 1'b1; t1 = mk(csl_pkg::K_EOF, 3'd0, pos_ff[15:0], 17'd0, 64'd0);
            end else begin
               n0 = 1'b1; t0 = mk(csl_pkg::K_EOF, 3'd0, pos_ff[15:0], 17'd0, 64'd0);
            end
         end
      end else if (mode_ff != csl_pkg::M_ERR) begin
         unique case (mode_ff)
            csl_pkg::M_STR: begin
               if (over) begin
                  n0 = 1'b1; t0 = mk(csl_pkg::K_INVALID, 3'd0, pos_ff[15:0], 17'd0, 64'd0);
                  mode_in = csl_pkg::M_ERR;
               end else if (cls == csl_pkg::C_QUOTE) begin
                  n0 = 1'b1; t0 = mk(csl_pkg::K_STR, 3'd0, start_ff, tlen + 17'd1, 64'd0);
                  mode_in = csl_pkg::M_IDLE;
               end else if (q_item.is_nl) begin
                  n0 = 1'b1; t0 = mk(csl_pkg::K_UNCLOSED, 3'd0, start_ff, 17'd0, 64'd0);
                  mode_in = csl_pkg::M_ERR;
               end
            end
            csl_pkg::M_NUM: begin
               if (cls == csl_pkg::C_DIGIT && !over) acc_in = acc10;
               else begin
                  n0 = 1'b1; t0 = mk(csl_pkg::K_NUM, 3'd0, start_ff, tlen, acc_ff);
                  mode_in = csl_pkg::M_IDLE; fresh = 1'b1;
               end
            end
            csl_pkg::M_IDENT: begin
               if ((cls == csl_pkg::C_ALPHA || cls == csl_pkg::C_DIGIT) && !over)
                  cand_in = narrowed;
               else begin
                  n0 = 1'b1; t0 = ident_tok(cand_ff, start_ff, tlen);
                  mode_in = csl_pkg::M_IDLE; fresh = 1'b1;
               end
            end
            csl_pkg::M_PEND: begin
               n0 = 1'b1; mode_in = csl_pkg::M_IDLE;
               if (q_item.is_eq && !over)
                  t0 = mk(csl_pkg::K_PUNCT, 3'd0, start_ff, 17'd2, 64'd0);
               else begin
                  t0 = mk(csl_pkg::K_PUNCT, 3'd0, start_ff, 17'd1, 64'd0);
                  fresh = 1'b1;
               end
            end
            default: begin
               mode_in = csl_pkg::M_IDLE; fresh = 1'b1;
            end
         endcase
         if (fresh) begin
            csl_pkg::token_type tb;
            logic nb;
            nb = 1'b0;
            tb = mk(csl_pkg::K_INVALID, 3'd0, pos_ff[15:0], 17'd0, 64'd0);
            if (over) begin
               nb = 1'b1; mode_in = csl_pkg::M_ERR;
            end else if (cls != csl_pkg::C_SPACE) begin
               start_in = pos_ff[15:0];
               case (cls)
                  csl_pkg::C_DIGIT: begin
                     mode_in = csl_pkg::M_NUM; acc_in = {60'd0, c[3:0]};
                  end
                  csl_pkg::C_QUOTE: mode_in = csl_pkg::M_STR;
                  csl_pkg::C_ALPHA: begin
                     mode_in = csl_pkg::M_IDENT; cand_in = first_cand;
                  end
                  csl_pkg::C_PEND:  mode_in = csl_pkg::M_PEND;
                  csl_pkg::C_PUNCT: begin
                     nb = 1'b1;
                     tb = mk(csl_pkg::K_PUNCT, 3'd0, pos_ff[15:0], 17'd1, 64'd0);
                  end
                  default: begin
                     nb = 1'b1; mode_in = csl_pkg::M_ERR;
                  end
               endcase
            end
            if (nb) begin
               if (n0) begin n1 = 1'b1; t1 = tb; end
               else begin n0 = 1'b1; t0 = tb; end
            end
         end
         if (mode_in != csl_pkg::M_ERR) pos_in = pos_ff + 17'd1;
      end
      if (n1) t1.last = 1'b1;
      else t0.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= csl_pkg::M_IDLE; pos_ff <= '0; start_ff <= '0;
         acc_ff <= '0; cand_ff <= '1;
         rw_ff <= '0; rr_ff <= '0;
      end else begin
         if (q_take) begin
            if (rewind) begin
               mode_ff <= csl_pkg::M_IDLE; pos_ff <= '0; start_ff <= '0;
               acc_ff <= '0; cand_ff <= '1;
            end else begin
               mode_ff <= mode_in; pos_ff <= pos_in; start_ff <= start_in;
               acc_ff <= acc_in; cand_ff <= cand_in;
            end
            rw_ff <= rw_ff + (csl_pkg::RAW+1)'(n0) + (csl_pkg::RAW+1)'(n1);
         end
         if (pop && !empty) rr_ff <= rr_ff + (csl_pkg::RAW+1)'(1);
      end
      if (q_take && n0) rq_ff[rw_ff[csl_pkg::RAW-1:0]] <= t0;
      if (q_take && n1) rq_ff[2'(rw_ff[csl_pkg::RAW-1:0] + 2'd1)] <= t1;
   end
endmodule
`default_nettype wire

FILE: hdl/c_subset_lexer.sv
`default_nettype none
// Streaming C-subset tokenizer. Bytes enter through a queue-style port
// (push/full) and tokens leave through another (pop/empty). A front end
// classifies each byte into a four-entry byte queue; the back end runs the
// lexer state machine at one byte per cycle and writes up to two tokens per
// byte into a four-entry token queue, so sustained rate is one byte per
// clock as long as tokens are popped; the back end stalls only when the
// token queue has fewer than two free slots. Tokens show on the rsp_ ports
// from the head of the token queue. A zero byte ends the text, emits EOF
// (UNCLOSED inside a string, nothing after an error) and rewinds the
// position; run_last marks the final token caused by a byte.
module c_subset_lexer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [7:0]  req_text_byte,
   output logic             empty,
   input  wire logic        pop,
   output logic [2:0]       rsp_token_kind,
   output logic [2:0]       rsp_keyword_index,
   output logic [15:0]      rsp_token_offset,
   output logic [16:0]      rsp_token_length,
   output logic [63:0]      rsp_number_value,
   output logic             rsp_run_last
);
   logic                   q_valid, q_take;
   csl_pkg::byte_item_type q_item;
   csl_pkg::token_type     tok;

   csl_front u_front (
      .clock(clock), .reset(reset), .push(push), .text_byte(req_text_byte),
      .full(full), .q_valid(q_valid), .q_item(q_item), .q_take(q_take)
   );

   csl_back u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_item(q_item),
      .q_take(q_take), .empty(empty), .pop(pop), .tok(tok)
   );

   assign rsp_token_kind    = tok.kind;
   assign rsp_keyword_index = tok.kw;
   assign rsp_token_offset  = tok.off;
   assign rsp_token_length  = tok.len;
   assign rsp_number_value  = tok.val;
   assign rsp_run_last      = tok.last;
endmodule
`default_nettype wire

FILE: hdl/csl_checker.sv
`default_nettype none
module csl_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        full,
   input wire logic        empty,
   input wire logic        pop,
   input wire logic [2:0]  rsp_token_kind,
   input wire logic [2:0]  rsp_keyword_index,
   input wire logic [16:0] rsp_token_length,
   input wire logic [63:0] rsp_number_value
);
   a_reset_empty: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("not empty after reset");
   a_kw_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_token_kind != csl_pkg::K_KW) |-> rsp_keyword_index == 3'd0)
      else $error("keyword index on non-keyword");
   a_val_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_token_kind != csl_pkg::K_NUM) |-> rsp_number_value == 64'd0)
      else $error("value on non-number");
   a_eof_len: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_token_kind == csl_pkg::K_EOF || rsp_token_kind == csl_pkg::K_INVALID))
      |-> rsp_token_length == 17'd0)
      else $error("length on eof/error");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> !empty && $stable(rsp_token_kind))
      else $error("waiting item changed");
endmodule

bind c_subset_lexer csl_checker u_csl_checker (
   .clock(clock), .reset(reset), .full(full), .empty(empty), .pop(pop),
   .rsp_token_kind(rsp_token_kind), .rsp_keyword_index(rsp_keyword_index),
   .rsp_token_length(rsp_token_length), .rsp_number_value(rsp_number_value)
);
`default_nettype wire
